// File: hw/rtl/spd_pkg.sv
// shared types, register codes and constants of the scratch pixel detector
package spd_pkg;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 12;
  localparam int DIM_W     = 13;
  localparam int THR_W     = 8;
  localparam int IDX_W     = 2;
  localparam int WIN_DEPTH = 11;
  localparam int LAG       = 5;
  localparam int SUB_W     = 3;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [THR_W-1:0] thr_t;
  typedef logic [IDX_W-1:0] reg_idx_t;

  // configuration register indexes
  localparam reg_idx_t REG_FRAME_WIDTH       = 2'd0;
  localparam reg_idx_t REG_FRAME_HEIGHT      = 2'd1;
  localparam reg_idx_t REG_MEDIAN_THRESHOLD  = 2'd2;
  localparam reg_idx_t REG_AVERAGE_THRESHOLD = 2'd3;

  localparam dim_t RST_FRAME_WIDTH       = 13'd640;
  localparam dim_t RST_FRAME_HEIGHT      = 13'd480;
  localparam thr_t RST_MEDIAN_THRESHOLD  = 8'd3;
  localparam thr_t RST_AVERAGE_THRESHOLD = 8'd20;

  localparam dim_t MIN_WIDTH  = 13'd12;
  localparam dim_t MIN_HEIGHT = 13'd3;
  localparam dim_t DIM_LIMIT  = 13'd4096;

  // one classified pixel waiting to be turned into results
  typedef struct packed {
    logic   mark;
    count_t column;
    count_t row;
    logic   row_end;
  } job_t;

endpackage

// File: hw/rtl/spd_ifs.sv
// valid/ready channel interfaces for pixels, results and configuration writes
interface spd_pix_if;
  logic            valid;
  logic            ready;
  spd_pkg::pixel_t pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface spd_res_if;
  logic            valid;
  logic            ready;
  logic            mark;
  spd_pkg::count_t column;
  spd_pkg::count_t row;
  logic            last_of_run;
  modport source (output valid, output mark, output column, output row,
                  output last_of_run, input ready);
  modport sink   (input valid, input mark, input column, input row,
                  input last_of_run, output ready);
endinterface

interface spd_cfg_if;
  logic              valid;
  logic              ready;
  spd_pkg::reg_idx_t index;
  spd_pkg::dim_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/spd_front.sv
// front end: config registers, counters, pixel window and candidate test
module spd_front (
  input  logic            clk,
  input  logic            rst_n,
  spd_pix_if.sink         in_ch,
  spd_cfg_if.sink         cfg_ch,
  input  logic            q_full,
  output logic            q_push,
  output spd_pkg::job_t   q_job
);
  import spd_pkg::*;

  function automatic pixel_t lower_median(input pixel_t a, input pixel_t b,
                                          input pixel_t c, input pixel_t d);
    pixel_t lo_ab, hi_ab, lo_cd, hi_cd, hi_of_lo, lo_of_hi;
    lo_ab    = (a > b) ? b : a;
    hi_ab    = (a > b) ? a : b;
    lo_cd    = (c > d) ? d : c;
    hi_cd    = (c > d) ? c : d;
    hi_of_lo = (lo_ab > lo_cd) ? lo_ab : lo_cd;
    lo_of_hi = (hi_ab > hi_cd) ? hi_cd : hi_ab;
    return (hi_of_lo > lo_of_hi) ? lo_of_hi : hi_of_lo;
  endfunction

  dim_t   width_r, height_r;
  thr_t   med_thr_r, avg_thr_r;
  count_t col_r, col_nxt;
  count_t row_r, row_nxt;
  pixel_t win_r [WIN_DEPTH];
  pixel_t win_s [WIN_DEPTH];

  dim_t              w_eff, h_eff;
  logic              accept, row_end, row_ok, col_ok, has_centre;
  count_t            x;
  pixel_t            med, pix_c;
  logic [PIX_W-1:0]  med_diff;
  logic [PIX_W+1:0]  left_sum, right_sum, side_diff, avg_bound;
  logic              t_med, t_avg;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full;
  assign accept       = in_ch.valid && !q_full;

  // clamp the frame size to its legal range
  always_comb begin
    if (width_r < MIN_WIDTH)       w_eff = MIN_WIDTH;
    else if (width_r > DIM_LIMIT)  w_eff = DIM_LIMIT;
    else                           w_eff = width_r;
    if (height_r < MIN_HEIGHT)     h_eff = MIN_HEIGHT;
    else if (height_r > DIM_LIMIT) h_eff = DIM_LIMIT;
    else                           h_eff = height_r;
  end

  // window after the incoming pixel is shifted in, index k is column c-k
  always_comb begin
    win_s[0] = in_ch.pixel;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      win_s[i] = win_r[i-1];
    end
  end

  always_comb begin
    row_end    = ({1'b0, col_r} + 13'd1) >= w_eff;
    row_ok     = (row_r > 12'd1) && (({1'b0, row_r} + 13'd1) < h_eff);
    has_centre = col_r >= count_t'(LAG);
    x          = col_r - count_t'(LAG);
    col_ok     = (x > 12'd5) && (({1'b0, x} + 13'd5) < w_eff);

    pix_c     = win_s[5];
    med       = lower_median(win_s[6], win_s[4], win_s[7], win_s[3]);
    med_diff  = (pix_c > med) ? (pix_c - med) : (med - pix_c);
    left_sum  = {2'b00, win_s[8]} + {2'b00, win_s[9]} + {2'b00, win_s[10]};
    right_sum = {2'b00, win_s[2]} + {2'b00, win_s[1]} + {2'b00, win_s[0]};
    side_diff = (left_sum > right_sum) ? (left_sum - right_sum)
                                       : (right_sum - left_sum);
    avg_bound = {1'b0, avg_thr_r, 1'b0} + {2'b00, avg_thr_r};
    t_med     = med_diff > med_thr_r;
    t_avg     = side_diff < avg_bound;

    if (row_end) begin
      col_nxt = '0;
      row_nxt = (({1'b0, row_r} + 13'd1) >= h_eff) ? '0 : row_r + 12'd1;
    end else begin
      col_nxt = col_r + 12'd1;
      row_nxt = row_r;
    end
  end

  assign q_push        = accept && has_centre;
  assign q_job.mark    = row_ok && col_ok && t_med && t_avg;
  assign q_job.column  = x;
  assign q_job.row     = row_r;
  assign q_job.row_end = row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_FRAME_WIDTH;
      height_r  <= RST_FRAME_HEIGHT;
      med_thr_r <= RST_MEDIAN_THRESHOLD;
      avg_thr_r <= RST_AVERAGE_THRESHOLD;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FRAME_WIDTH:       width_r   <= cfg_ch.data;
        REG_FRAME_HEIGHT:      height_r  <= cfg_ch.data;
        REG_MEDIAN_THRESHOLD:  med_thr_r <= cfg_ch.data[THR_W-1:0];
        REG_AVERAGE_THRESHOLD: avg_thr_r <= cfg_ch.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_s[i];
      end
    end
  end

endmodule

// File: hw/rtl/spd_queue.sv
// small job queue between the front end and the result sequencer
module spd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  spd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output spd_pkg::job_t head,
  output logic          empty
);
  import spd_pkg::*;

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

  job_t              slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = cnt_r == FULL_CNT;
  assign empty   = cnt_r == '0;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: hw/rtl/spd_back.sv
// back end: expands each job into its results and holds the output register
module spd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  spd_pkg::job_t q_head,
  output logic          q_pop,
  spd_res_if.source     out_ch
);
  import spd_pkg::*;

  localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(LAG);

  logic [SUB_W-1:0] sub_r, sub_nxt;
  logic             vld_r, vld_nxt;
  logic             mark_r, last_r;
  count_t           col_r, row_r;
  logic             emit, job_done;

  // a slot in the output register opens when it is empty or being taken
  assign emit     = !q_empty && (!vld_r || out_ch.ready);
  assign job_done = !q_head.row_end || (sub_r == LAST_SUB);
  assign q_pop    = emit && job_done;

  always_comb begin
    sub_nxt = sub_r;
    vld_nxt = vld_r;
    if (emit) begin
      vld_nxt = 1'b1;
      sub_nxt = job_done ? '0 : sub_r + 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      vld_r <= vld_nxt;
    end
  end

  // only the pixel itself can be marked, the row end burst carries zeros
  always_ff @(posedge clk) begin
    if (emit) begin
      mark_r <= (sub_r == '0) && q_head.mark;
      col_r  <= q_head.column + count_t'(sub_r);
      row_r  <= q_head.row;
      last_r <= job_done;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.mark        = mark_r;
  assign out_ch.column      = col_r;
  assign out_ch.row         = row_r;
  assign out_ch.last_of_run = last_r;

endmodule

// File: hw/rtl/scratch_pixel_detector.sv
// top level of the vertical scratch pixel detector
// Takes one smoothed 8-bit pixel per cycle in raster order while the queue is
// not full and returns one result per pixel, five pixels behind the input:
// mark, column and row of the pixel, and last_of_run on the final result
// caused by an input pixel. The first five pixels of a row give no result;
// the last pixel of a row gives a burst of six results, one per cycle on the
// output channel while it is ready. The front end classifies a pixel in the
// cycle it is accepted and places it in a queue of QUEUE_DEPTH entries; the
// result sequencer drains that queue at one result per cycle while the output
// is ready, so the input runs at one pixel per cycle except that the extra
// results of a row end are absorbed by the queue until it fills. Configuration
// writes are always taken and should be made while the block is idle.
module scratch_pixel_detector #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  spd_pix_if.sink   in_ch,
  spd_res_if.source out_ch,
  spd_cfg_if.sink   cfg_ch
);
  import spd_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  job_t q_job, q_head;

  spd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_job)
  );

  spd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  spd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
